[hw/rtl/imf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IMU window filter package
// Shared constants and control types of the six-axis window filter.
// ----------------------------------------------------------------------------
package imf_pkg;

	// Three accelerometer axes followed by three gyroscope axes.
	localparam int AXES = 6;

	// Position flags for one step of the sorted-window merge.
	typedef struct packed {
		logic first;
		logic last;
	} merge_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/imf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IMU window filter channels
// Valid/ready channels for raw six-axis samples and for filtered results.
// ----------------------------------------------------------------------------
interface imf_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;
	logic signed [SAMPLE_BITS-1:0] gyro_x;
	logic signed [SAMPLE_BITS-1:0] gyro_y;
	logic signed [SAMPLE_BITS-1:0] gyro_z;

	modport source (
		output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input  ready
	);
	modport sink (
		input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output ready
	);
endinterface

interface imf_filtered_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered_accel_x;
	logic signed [SAMPLE_BITS-1:0] filtered_accel_y;
	logic signed [SAMPLE_BITS-1:0] filtered_accel_z;
	logic signed [SAMPLE_BITS-1:0] filtered_gyro_x;
	logic signed [SAMPLE_BITS-1:0] filtered_gyro_y;
	logic signed [SAMPLE_BITS-1:0] filtered_gyro_z;

	modport source (
		output valid, filtered_accel_x, filtered_accel_y, filtered_accel_z,
		       filtered_gyro_x, filtered_gyro_y, filtered_gyro_z,
		input  ready
	);
	modport sink (
		input  valid, filtered_accel_x, filtered_accel_y, filtered_accel_z,
		       filtered_gyro_x, filtered_gyro_y, filtered_gyro_z,
		output ready
	);
endinterface
`default_nettype wire

[hw/rtl/imf_row_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IMU window filter row memory
// Single-write, single-read synchronous RAM with registered read data and a
// per-row valid bit, so that rows never written since reset read as zero.
// ----------------------------------------------------------------------------
module imf_row_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 96
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

[hw/rtl/imf_merge_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IMU window filter merge lane
// One step of the sorted-window update for one axis: drops the oldest sample
// from the sorted stream and inserts the newest one in order.
// ----------------------------------------------------------------------------
module imf_merge_lane
	import imf_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic signed [SAMPLE_BITS-1:0] cur,
	input  wire logic signed [SAMPLE_BITS-1:0] nxt,
	input  wire logic signed [SAMPLE_BITS-1:0] old_v,
	input  wire logic signed [SAMPLE_BITS-1:0] new_v,
	input  wire logic signed [SAMPLE_BITS-1:0] sp_prev,
	input  wire merge_ctl_t                    ctl,
	output logic signed [SAMPLE_BITS-1:0]      sp,
	output logic signed [SAMPLE_BITS-1:0]      t
);

	logic                          skip;
	logic                          sp_inf;
	logic signed [SAMPLE_BITS-1:0] low_side;

	// Once the first copy of the old sample is reached, the stream without it
	// is the sorted window shifted down by one entry.
	assign skip   = !(cur < old_v);
	assign sp_inf = skip && ctl.last;
	assign sp     = skip ? nxt : cur;

	// The new entry is the new sample clamped between the neighbors of the
	// reduced stream.
	assign low_side = (sp_inf || (new_v < sp)) ? new_v : sp;
	assign t        = (ctl.first || (low_side > sp_prev)) ? low_side : sp_prev;

endmodule
`default_nettype wire

[hw/rtl/imf_mean_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IMU window filter mean divider
// Floor division of six window sums by the window length through a multiply
// by the rounded-up reciprocal; the biased sums are registered at start, then the quotients.
// ----------------------------------------------------------------------------
module imf_mean_div
	import imf_pkg::*;
#(
	parameter int WINDOW      = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                                  clk,
	input  wire logic                                                  arst_n,
	input  wire logic                                                  start,
	input  wire logic signed [SAMPLE_BITS+$clog2(WINDOW):0]            sum [AXES],
	output logic                                                       busy,
	output logic signed [SAMPLE_BITS-1:0]                              quot [AXES]
);

	localparam int UW    = SAMPLE_BITS + $clog2(WINDOW) + 1;
	localparam int SHIFT = UW + $clog2(WINDOW);
	localparam int MW    = UW + 1;
	localparam int PW    = UW + MW;
	// Half the sample range times the window length; moves every sum into the
	// non-negative range.
	localparam logic [UW-1:0] BIAS = UW'(WINDOW) << (SAMPLE_BITS - 1);
	// The rounding error of this reciprocal stays below one part in WINDOW over
	// the whole biased range, so the truncated product is the exact floor.
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic                   busy_q;
	logic [UW-1:0]          bsum_q [AXES];
	logic [SAMPLE_BITS-1:0] quo_q  [AXES];
	logic [PW-1:0]          prod   [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			prod[a] = PW'(bsum_q[a]) * PW'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int a = 0; a < AXES; a++) begin
				bsum_q[a] <= $unsigned(sum[a]) + BIAS;
			end
		end
		if (busy_q) begin
			for (int a = 0; a < AXES; a++) begin
				quo_q[a] <= prod[a][SHIFT +: SAMPLE_BITS];
			end
		end
	end

	assign busy = busy_q;

	// The quotient of the biased sum carries half the sample range; flipping
	// the sign bit removes it.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			quot[a] = {~quo_q[a][SAMPLE_BITS-1], quo_q[a][SAMPLE_BITS-2:0]};
		end
	end

endmodule
`default_nettype wire

[hw/rtl/imu_window_median_average_filter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IMU window median/average filter
// Six-axis sliding-window filter giving the window mean or median per axis.
// ----------------------------------------------------------------------------
// Usage:
// One transaction on the samples channel carries three accelerometer and
// three gyroscope values; each produces exactly one transaction on the
// results channel with the filtered value of every axis. filter_mode is
// written through cfg_we/cfg_wdata: 0 gives the floor of the window mean,
// 1 (reset value) the window median. The user must write it only while the
// block is idle; the block itself does not enforce this.
// The raw window sits in a ring memory and a sorted copy of each axis in a
// second memory. Each sample triggers one read-modify-write sweep over the
// sorted rows, one row per cycle; the mean path then adds a pass through the
// reciprocal divider.
// One sample is processed at a time; the result register lets the next
// sample enter while a finished result is still waiting for the receiver.
// A stalled receiver holds the last step until the register frees up.
// Reset empties both memories through per-row valid bits (the window reads
// as all zero), sets the write position to zero and selects the median.
// ----------------------------------------------------------------------------
module imu_window_median_average_filter_top
	import imf_pkg::*;
#(
	parameter int WINDOW      = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	imf_sample_if.sink     samples,
	imf_filtered_if.source results
);

	localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUMW   = SAMPLE_BITS + $clog2(WINDOW) + 1;
	localparam int RW     = AXES * SAMPLE_BITS;
	localparam int LO_IDX = (WINDOW - 1) / 2;
	localparam int HI_IDX = WINDOW / 2;

	typedef enum logic [2:0] {
		IDLE,
		LOAD,
		PASS,
		DIV_START,
		DIV_RUN,
		DONE
	} state_t;

	state_t  state_q;
	logic    filter_mode_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] k_q;
	logic    out_valid_q;
	logic signed [SAMPLE_BITS-1:0] res_q [AXES];

	logic accept;
	logic res_load;

	logic signed [SAMPLE_BITS-1:0] in_smp    [AXES];
	logic signed [SAMPLE_BITS-1:0] sample_q  [AXES];
	logic signed [SAMPLE_BITS-1:0] old_smp   [AXES];
	logic signed [SAMPLE_BITS-1:0] srt_smp   [AXES];
	logic signed [SAMPLE_BITS-1:0] cur_q     [AXES];
	logic signed [SAMPLE_BITS-1:0] sp_prev_q [AXES];
	logic signed [SAMPLE_BITS-1:0] sp        [AXES];
	logic signed [SAMPLE_BITS-1:0] t         [AXES];
	logic signed [SAMPLE_BITS-1:0] lo_q      [AXES];
	logic signed [SAMPLE_BITS-1:0] hi_q      [AXES];
	logic signed [SAMPLE_BITS-1:0] med       [AXES];
	logic signed [SAMPLE_BITS-1:0] mean      [AXES];
	logic signed [SUMW-1:0]        sum_q     [AXES];
	logic signed [SAMPLE_BITS:0]   mid_sum   [AXES];

	logic [RW-1:0] ring_wdata;
	logic [RW-1:0] ring_rdata;
	logic [RW-1:0] srt_wdata;
	logic [RW-1:0] srt_rdata;

	logic          srt_we;
	logic          srt_re;
	logic [AW-1:0] srt_raddr;
	logic [AW+1:0] rd_idx;
	logic          rd_ok;
	logic          k_last;
	merge_ctl_t    ctl;

	logic div_start;
	logic div_busy;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = (state_q == IDLE);

	assign in_smp[0] = samples.accel_x;
	assign in_smp[1] = samples.accel_y;
	assign in_smp[2] = samples.accel_z;
	assign in_smp[3] = samples.gyro_x;
	assign in_smp[4] = samples.gyro_y;
	assign in_smp[5] = samples.gyro_z;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			ring_wdata[a*SAMPLE_BITS +: SAMPLE_BITS] = in_smp[a];
			srt_wdata[a*SAMPLE_BITS +: SAMPLE_BITS]  = t[a];
			old_smp[a] = ring_rdata[a*SAMPLE_BITS +: SAMPLE_BITS];
			srt_smp[a] = srt_rdata[a*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	// Raw history: the new sample replaces the oldest one, whose value is
	// read out at the same edge for the sorted update.
	imf_row_ram #(
		.DEPTH (WINDOW),
		.WIDTH (RW)
	) u_ring_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (accept),
		.waddr  (pos_q),
		.wdata  (ring_wdata),
		.re     (accept),
		.raddr  (pos_q),
		.rdata  (ring_rdata)
	);

	// Sorted window: row k holds the k-th smallest value of every axis. The
	// sweep reads two rows ahead of the row it writes back.
	assign k_last = (k_q == AW'(WINDOW - 1));
	assign rd_idx = (AW + 2)'(k_q) + (AW + 2)'(2);
	assign rd_ok  = rd_idx < (AW + 2)'(WINDOW);
	assign srt_we = (state_q == PASS);

	always_comb begin
		priority if (accept) begin
			srt_re    = 1'b1;
			srt_raddr = '0;
		end else if (state_q == LOAD) begin
			srt_re    = (WINDOW > 1);
			srt_raddr = AW'(1);
		end else if (state_q == PASS) begin
			srt_re    = rd_ok;
			srt_raddr = rd_idx[AW-1:0];
		end else begin
			srt_re    = 1'b0;
			srt_raddr = '0;
		end
	end

	imf_row_ram #(
		.DEPTH (WINDOW),
		.WIDTH (RW)
	) u_sort_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (srt_we),
		.waddr  (k_q),
		.wdata  (srt_wdata),
		.re     (srt_re),
		.raddr  (srt_raddr),
		.rdata  (srt_rdata)
	);

	assign ctl.first = (k_q == '0);
	assign ctl.last  = k_last;

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		imf_merge_lane #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.cur     (cur_q[a]),
			.nxt     (srt_smp[a]),
			.old_v   (old_smp[a]),
			.new_v   (sample_q[a]),
			.sp_prev (sp_prev_q[a]),
			.ctl     (ctl),
			.sp      (sp[a]),
			.t       (t[a])
		);
	end

	assign div_start = (state_q == DIV_START);

	imf_mean_div #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mean_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum    (sum_q),
		.busy   (div_busy),
		.quot   (mean)
	);

	// For an odd window both middle indexes coincide and the halving is exact.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			mid_sum[a] = (SAMPLE_BITS + 1)'(lo_q[a]) + (SAMPLE_BITS + 1)'(hi_q[a]);
			med[a]     = mid_sum[a][SAMPLE_BITS:1];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= in_smp;
		end
		if (state_q == LOAD) begin
			cur_q <= srt_smp;
		end
		if (state_q == PASS) begin
			cur_q     <= srt_smp;
			sp_prev_q <= sp;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= (ctl.first ? SUMW'(0) : sum_q[a]) + SUMW'(t[a]);
				if (k_q == AW'(LO_IDX)) begin
					lo_q[a] <= t[a];
				end
				if (k_q == AW'(HI_IDX)) begin
					hi_q[a] <= t[a];
				end
			end
		end
	end

	assign res_load = (state_q == DONE) && (!out_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			filter_mode_q <= 1'b1;
			pos_q         <= '0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				res_q[a] <= '0;
			end
		end else begin
			if (cfg_we) begin
				filter_mode_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						pos_q   <= (pos_q == AW'(WINDOW - 1)) ? '0 : pos_q + AW'(1);
						state_q <= LOAD;
					end
				end
				LOAD: begin
					k_q     <= '0;
					state_q <= PASS;
				end
				PASS: begin
					k_q <= k_q + AW'(1);
					if (k_last) begin
						state_q <= filter_mode_q ? DONE : DIV_START;
					end
				end
				DIV_START: begin
					state_q <= DIV_RUN;
				end
				DIV_RUN: begin
					if (!div_busy) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (res_load) begin
						for (int a = 0; a < AXES; a++) begin
							res_q[a] <= filter_mode_q ? med[a] : mean[a];
						end
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign results.valid            = out_valid_q;
	assign results.filtered_accel_x = res_q[0];
	assign results.filtered_accel_y = res_q[1];
	assign results.filtered_accel_z = res_q[2];
	assign results.filtered_gyro_x  = res_q[3];
	assign results.filtered_gyro_y  = res_q[4];
	assign results.filtered_gyro_z  = res_q[5];

	// The sweep must never read the row it is writing back in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(srt_we && srt_re) |-> (srt_raddr != k_q))
		else $error("sorted memory read and write collide on one row");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_START) |=> div_busy)
		else $error("divider did not start");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DONE && !filter_mode_q) |-> !div_busy)
		else $error("mean result taken while divider still running");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(state_q == DONE))
		else $error("result presented without a finished sweep");

endmodule
`default_nettype wire
